// File: hw/rtl/dpns_pkg.sv
package dpns_pkg;

  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
  localparam logic [15:0] FOCAL_RESET = 16'd525;
  localparam logic [22:0] DEG85_Q16   = 23'd5570560;
  localparam logic [22:0] DEG90_Q16   = 23'd5898240;

  // arccos polynomial, signed Q16 degrees
  localparam logic signed [24:0] HC0 = 25'sd5897986;
  localparam logic signed [24:0] HC1 = -25'sd796476;
  localparam logic signed [24:0] HC2 = 25'sd278845;
  localparam logic signed [24:0] HC3 = -25'sd70327;

  localparam logic [24:0] K0    = 25'd13421773;
  localparam logic [19:0] KR    = 20'd570425;
  localparam logic [19:0] Z_OFF = 20'd26214;
  localparam logic [22:0] A0    = 23'd5153961;
  localparam logic [22:0] A2    = 23'd8160438;
  localparam logic [18:0] A3    = 19'd429497;

  typedef struct packed {
    logic              kill;
    logic [19:0]       z;
    logic signed [16:0] c;
  } s0_t;

  typedef struct packed {
    logic              kill;
    logic [19:0]       z;
    logic signed [16:0] c;
    logic [17:0]       sz;
    logic signed [24:0] h;
  } hn_t;

  typedef struct packed {
    logic        kill;
    logic        pos;
    logic [19:0] z;
    logic [17:0] sz;
    logic [22:0] h;
  } sa_t;

  typedef struct packed {
    logic        kill;
    logic [19:0] z;
    logic [17:0] sz;
  } tr_t;

  typedef struct packed {
    logic        kill;
    logic [17:0] sz;
    logic [42:0] t3num;
    logic [30:0] term2;
  } dl_t;

  typedef struct packed {
    logic        kill;
    logic [24:0] lat;
    logic [30:0] term2;
  } da_t;

  // signed divide by 2^15, truncating toward zero
  function automatic logic signed [26:0] tz15(input logic signed [41:0] x);
    logic signed [41:0] y;
    y = x[41] ? x + 42'sd32767 : x;
    return 27'(y >>> 15);
  endfunction

endpackage

// File: hw/rtl/dpns_div_cell.sv
module dpns_div_cell #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_x,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [DW-1:0] out_rem,
  output logic [QW-1:0] out_x,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  logic [DW:0]   t;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;
  logic [QW-1:0] x_next;

  always_comb begin
    t        = {in_rem, in_x[QW-1]};
    diff     = t - {1'b0, in_den};
    ge       = (t >= {1'b0, in_den});
    rem_next = ge ? diff[DW-1:0] : t[DW-1:0];
    x_next   = {in_x[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_x    <= x_next;
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule

// File: hw/rtl/dpns_div.sv
module dpns_div #(
  parameter int NW = 39,
  parameter int DW = 23,
  parameter int QW = 21,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] x    [0:QW];
  logic [DW-1:0] dens [0:QW];
  logic [SW-1:0] side [0:QW];

  assign vld[0]  = in_vld;
  assign x[0]    = num[QW-1:0];
  assign dens[0] = den;
  assign side[0] = in_side;

  // high numerator bits start as the remainder, they stay below the divisor
  generate
    if (NW > QW) begin : g_hi
      assign rem[0] = DW'(num[NW-1:QW]);
    end else begin : g_nohi
      assign rem[0] = '0;
    end
  endgenerate

  for (genvar i = 0; i < QW; i++) begin : g_cell
    dpns_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (vld[i]),
      .in_rem  (rem[i]),
      .in_x    (x[i]),
      .in_den  (dens[i]),
      .in_side (side[i]),
      .out_vld (vld[i+1]),
      .out_rem (rem[i+1]),
      .out_x   (x[i+1]),
      .out_den (dens[i+1]),
      .out_side(side[i+1])
    );
  end

  assign out_vld  = vld[QW];
  assign quo      = x[QW];
  assign out_side = side[QW];

endmodule

// File: hw/rtl/dpns_sqrt_cell.sv
module dpns_sqrt_cell #(
  parameter int IW = 36,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [IW-1:0]   in_rad,
  input  logic [IW/2:0]   in_rem,
  input  logic [IW/2-1:0] in_root,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [IW-1:0]   out_rad,
  output logic [IW/2:0]   out_rem,
  output logic [IW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int OW = IW / 2;

  logic [OW+1:0] t;
  logic [OW+1:0] trial;
  logic [OW+1:0] diff;
  logic          ge;
  logic [OW:0]   rem_next;
  logic [OW-1:0] root_next;

  always_comb begin
    t         = {in_rem[OW-1:0], in_rad[IW-1:IW-2]};
    trial     = {in_root, 2'b01};
    diff      = t - trial;
    ge        = (t >= trial);
    rem_next  = ge ? diff[OW:0] : t[OW:0];
    root_next = {in_root[OW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= {in_rad[IW-3:0], 2'b00};
      out_rem  <= rem_next;
      out_root <= root_next;
      out_side <= in_side;
    end
  end

endmodule

// File: hw/rtl/dpns_sqrt.sv
module dpns_sqrt #(
  parameter int IW = 36,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [IW-1:0]   rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [IW/2-1:0] root,
  output logic [SW-1:0]   out_side
);

  localparam int OW = IW / 2;

  logic          vld   [0:OW];
  logic [IW-1:0] rads  [0:OW];
  logic [OW:0]   rem   [0:OW];
  logic [OW-1:0] roots [0:OW];
  logic [SW-1:0] side  [0:OW];

  assign vld[0]   = in_vld;
  assign rads[0]  = rad;
  assign rem[0]   = '0;
  assign roots[0] = '0;
  assign side[0]  = in_side;

  // one result bit per cell, two radicand bits consumed each step
  for (genvar i = 0; i < OW; i++) begin : g_cell
    dpns_sqrt_cell #(.IW(IW), .SW(SW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (vld[i]),
      .in_rad  (rads[i]),
      .in_rem  (rem[i]),
      .in_root (roots[i]),
      .in_side (side[i]),
      .out_vld (vld[i+1]),
      .out_rad (rads[i+1]),
      .out_rem (rem[i+1]),
      .out_root(roots[i+1]),
      .out_side(side[i+1])
    );
  end

  assign out_vld  = vld[OW];
  assign root     = roots[OW];
  assign out_side = side[OW];

endmodule

// File: hw/rtl/depth_point_noise_sigma.sv
// channel | handshake             | word
// --------+-----------------------+--------------------------------------------
// in      | in_valid / in_ready   | point_valid, depth_z, normal_z
// out     | out_valid / out_ready | lateral_sd, axial_sd, saturated
// cfg     | cfg_we                | cfg_wdata -> focal_length_px
//
// one word per cycle sustained while the output is not held; the stages come from the cell chains:
// sqrt of depth (18), sqrt for the angle (15), theta ratio divide (21),
// lateral divide (25) and axial divide (36), plus 9 plain stages.
// the whole chain moves when the output register is empty or being taken.
// rst clears the valid bits and sets the focal length to 525.
module depth_point_noise_sigma (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               point_valid,
  input  logic [19:0]        depth_z,
  input  logic signed [15:0] normal_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        lateral_sd,
  output logic [31:0]        axial_sd,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  logic        en;
  logic [15:0] focal;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal <= dpns_pkg::FOCAL_RESET;
    end else if (cfg_we) begin
      focal <= cfg_wdata;
    end
  end

  // input stage
  logic               p0_vld;
  dpns_pkg::s0_t      p0;
  logic signed [16:0] nz17;

  assign nz17 = 17'(normal_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
    end else if (en) begin
      p0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0.kill <= !point_valid || (depth_z == '0);
      p0.z    <= depth_z;
      p0.c    <= -nz17;
    end
  end

  // sqrt of depth for the axial term
  logic          sz_vld;
  logic [17:0]   sz_root;
  logic [$bits(dpns_pkg::s0_t)-1:0] sz_side;
  dpns_pkg::s0_t sz_s;

  dpns_sqrt #(.IW(36), .SW($bits(dpns_pkg::s0_t))) u_sqrt_z (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (p0_vld),
    .rad     ({p0.z, 16'b0}),
    .in_side (p0),
    .out_vld (sz_vld),
    .root    (sz_root),
    .out_side(sz_side)
  );

  assign sz_s = dpns_pkg::s0_t'(sz_side);

  // arccos polynomial, one Horner step per stage
  logic               h1_vld;
  logic               h2_vld;
  dpns_pkg::hn_t      h1;
  dpns_pkg::hn_t      h2;
  logic signed [41:0] m1;
  logic signed [41:0] m2;
  logic signed [41:0] m3;
  logic signed [26:0] h3_sum;

  always_comb begin
    m1     = dpns_pkg::HC3 * sz_s.c;
    m2     = h1.h * h1.c;
    m3     = h2.h * h2.c;
    h3_sum = dpns_pkg::HC0 + dpns_pkg::tz15(m3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_vld <= 1'b0;
      h2_vld <= 1'b0;
    end else if (en) begin
      h1_vld <= sz_vld;
      h2_vld <= h1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1.kill <= sz_s.kill;
      h1.z    <= sz_s.z;
      h1.c    <= sz_s.c;
      h1.sz   <= sz_root;
      h1.h    <= 25'(dpns_pkg::HC2 + dpns_pkg::tz15(m1));
      h2.kill <= h1.kill;
      h2.z    <= h1.z;
      h2.c    <= h1.c;
      h2.sz   <= h1.sz;
      h2.h    <= 25'(dpns_pkg::HC1 + dpns_pkg::tz15(m2));
    end
  end

  logic          h3_vld;
  dpns_pkg::sa_t h3;
  logic [29:0]   h3_rad;
  logic          pos;
  logic [17:0]   one_minus;

  always_comb begin
    pos       = (h2.c > 17'sd0);
    one_minus = 18'd32768 - 18'(h2.c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h3_vld <= 1'b0;
    end else if (en) begin
      h3_vld <= h2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h3.kill <= h2.kill;
      h3.pos  <= pos;
      h3.z    <= h2.z;
      h3.sz   <= h2.sz;
      h3.h    <= h3_sum[26] ? 23'd0 : h3_sum[22:0];
      h3_rad  <= pos ? {one_minus[14:0], 15'b0} : 30'd0;
    end
  end

  // sqrt(1 - c) in Q15
  logic          sa_vld;
  logic [14:0]   sa_root;
  logic [$bits(dpns_pkg::sa_t)-1:0] sa_side;
  dpns_pkg::sa_t sa_s;

  dpns_sqrt #(.IW(30), .SW($bits(dpns_pkg::sa_t))) u_sqrt_a (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (h3_vld),
    .rad     (h3_rad),
    .in_side (h3),
    .out_vld (sa_vld),
    .root    (sa_root),
    .out_side(sa_side)
  );

  assign sa_s = dpns_pkg::sa_t'(sa_side);

  // theta in Q16 degrees
  logic          t_vld;
  logic [22:0]   th;
  dpns_pkg::tr_t tr;
  logic [37:0]   th_prod;
  logic [22:0]   th_next;

  always_comb begin
    th_prod = sa_s.h * sa_root;
    if (!sa_s.pos || (th_prod[37:15] > dpns_pkg::DEG85_Q16)) begin
      th_next = dpns_pkg::DEG85_Q16;
    end else begin
      th_next = th_prod[37:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else if (en) begin
      t_vld <= sa_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th      <= th_next;
      tr.kill <= sa_s.kill;
      tr.z    <= sa_s.z;
      tr.sz   <= sa_s.sz;
    end
  end

  // r = theta / (90 - theta), Q16
  logic          r_vld;
  logic [20:0]   r;
  logic [$bits(dpns_pkg::tr_t)-1:0] r_side;
  dpns_pkg::tr_t r_s;

  dpns_div #(.NW(39), .DW(23), .QW(21), .SW($bits(dpns_pkg::tr_t))) u_div_r (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (t_vld),
    .num     ({th, 16'b0}),
    .den     (dpns_pkg::DEG90_Q16 - th),
    .in_side (tr),
    .out_vld (r_vld),
    .quo     (r),
    .out_side(r_side)
  );

  assign r_s = dpns_pkg::tr_t'(r_side);

  // products for both sigmas
  logic        y1_vld;
  logic        y1_kill;
  logic [17:0] y1_sz;
  logic [24:0] y1_k;
  logic [39:0] y1_z2;
  logic [41:0] y1_rr;
  logic [39:0] y1_dd;
  logic [40:0] km;
  logic [19:0] d;

  always_comb begin
    km = dpns_pkg::KR * r;
    d  = (r_s.z >= dpns_pkg::Z_OFF) ? r_s.z - dpns_pkg::Z_OFF : dpns_pkg::Z_OFF - r_s.z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1_kill <= r_s.kill;
      y1_sz   <= r_s.sz;
      y1_k    <= dpns_pkg::K0 + km[40:16];
      y1_z2   <= r_s.z * r_s.z;
      y1_rr   <= r * r;
      y1_dd   <= d * d;
    end
  end

  logic        y2_vld;
  logic        y2_kill;
  logic [17:0] y2_sz;
  logic [24:0] y2_pnum;
  logic [39:0] y2_plo;
  logic [39:0] y2_phi;
  logic [42:0] y2_qlo;
  logic [42:0] y2_qhi;
  logic [56:0] p;

  assign p = y1_k * y1_z2[39:8];

  always_ff @(posedge clk) begin
    if (en) begin
      y2_kill <= y1_kill;
      y2_sz   <= y1_sz;
      y2_pnum <= p[56:32];
      y2_plo  <= dpns_pkg::A3 * y1_rr[20:0];
      y2_phi  <= dpns_pkg::A3 * y1_rr[41:21];
      y2_qlo  <= dpns_pkg::A2 * y1_dd[19:0];
      y2_qhi  <= dpns_pkg::A2 * y1_dd[39:20];
    end
  end

  logic          y3_vld;
  logic [24:0]   y3_pnum;
  dpns_pkg::dl_t y3;
  logic [61:0]   t3sum;
  logic [63:0]   qsum;

  always_comb begin
    t3sum = 62'(y2_plo) + (62'(y2_phi) << 21);
    qsum  = 64'(y2_qlo) + (64'(y2_qhi) << 20);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y1_vld <= 1'b0;
      y2_vld <= 1'b0;
      y3_vld <= 1'b0;
    end else if (en) begin
      y1_vld <= r_vld;
      y2_vld <= y1_vld;
      y3_vld <= y2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y3_pnum  <= y2_pnum;
      y3.kill  <= y2_kill;
      y3.sz    <= y2_sz;
      y3.t3num <= t3sum[58:16];
      y3.term2 <= qsum[62:32];
    end
  end

  // lateral: (k * z^2) / focal
  logic          l_vld;
  logic [24:0]   lat;
  logic [$bits(dpns_pkg::dl_t)-1:0] l_side;
  dpns_pkg::dl_t l_s;
  dpns_pkg::da_t a_in;

  dpns_div #(.NW(25), .DW(16), .QW(25), .SW($bits(dpns_pkg::dl_t))) u_div_l (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (y3_vld),
    .num     (y3_pnum),
    .den     (focal),
    .in_side (y3),
    .out_vld (l_vld),
    .quo     (lat),
    .out_side(l_side)
  );

  assign l_s        = dpns_pkg::dl_t'(l_side);
  assign a_in.kill  = l_s.kill;
  assign a_in.lat   = lat;
  assign a_in.term2 = l_s.term2;

  // axial angle term: r^2 / sqrt(z)
  logic          a_vld;
  logic [35:0]   q3;
  logic [$bits(dpns_pkg::da_t)-1:0] a_side;
  dpns_pkg::da_t a_s;

  dpns_div #(.NW(43), .DW(18), .QW(36), .SW($bits(dpns_pkg::da_t))) u_div_a (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (l_vld),
    .num     (l_s.t3num),
    .den     (l_s.sz),
    .in_side (a_in),
    .out_vld (a_vld),
    .quo     (q3),
    .out_side(a_side)
  );

  assign a_s = dpns_pkg::da_t'(a_side);

  // output register
  logic [36:0] ax_sum;
  logic        no_focal;

  always_comb begin
    ax_sum   = 37'(dpns_pkg::A0) + 37'(a_s.term2) + 37'(q3);
    no_focal = (focal == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lateral_sd <= (a_s.kill || no_focal) ? dpns_pkg::SAT32 : 32'(a_s.lat);
      axial_sd   <= a_s.kill ? dpns_pkg::SAT32 : 32'(ax_sum[36:16]);
      saturated  <= a_s.kill || no_focal;
    end
  end

endmodule

// File: tb/sv/depth_point_noise_sigma_tb.sv
`timescale 1ns / 1ps

class sigma_scoreboard;
  logic [15:0] focal;
  logic [31:0] lat_q[$];
  logic [31:0] ax_q[$];
  logic        sat_q[$];
  int          errors;
  int          checked;

  function new();
    focal = 16'd525;
    errors = 0;
    checked = 0;
  endfunction

  function logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // incidence angle in q16 degrees, clamped at 85
  function logic [63:0] incidence_q16(input logic signed [15:0] nz);
    longint c;
    longint h;
    logic [63:0] s;
    logic [63:0] th;
    c = -longint'(nz);
    if (c <= 0) return 64'd5570560;
    s = root64(64'(32768 - c) << 15);
    h = -70327;
    h = 278845 + (h * c) / 32768;
    h = -796476 + (h * c) / 32768;
    h = 5897986 + (h * c) / 32768;
    if (h < 0) h = 0;
    th = (64'(h) * s) >> 15;
    if (th > 64'd5570560) th = 64'd5570560;
    return th;
  endfunction

  function void note_point(input logic pv, input logic [19:0] z, input logic signed [15:0] nz);
    logic [63:0] th, r, k, z2, lat, d, ax, sz, zz;
    logic sat;
    sat = 0;
    zz = 64'(z);
    if (!pv || z == 0) begin
      lat_q.push_back(32'hFFFF_FFFF);
      ax_q.push_back(32'hFFFF_FFFF);
      sat_q.push_back(1'b1);
      return;
    end
    th = incidence_q16(nz);
    r = (th << 16) / (64'd5898240 - th);
    z2 = zz * zz;
    if (focal == 0) begin
      lat = 64'hFFFF_FFFF;
      sat = 1;
    end else begin
      k = 64'd13421773 + ((64'd570425 * r) >> 16);
      lat = (k * (z2 >> 8)) / (64'(focal) << 32);
      if (lat > 64'hFFFF_FFFF) begin
        lat = 64'hFFFF_FFFF;
        sat = 1;
      end
    end
    d = (zz >= 26214) ? zz - 26214 : 26214 - zz;
    sz = root64(zz << 16);
    ax = 64'd5153961 + ((64'd8160438 * (d * d)) >> 32) + (64'd429497 * (r * r)) / (sz << 16);
    ax = ax >> 16;
    if (ax > 64'hFFFF_FFFF) begin
      ax = 64'hFFFF_FFFF;
      sat = 1;
    end
    lat_q.push_back(lat[31:0]);
    ax_q.push_back(ax[31:0]);
    sat_q.push_back(sat);
  endfunction

  function void check_sigma(input logic [31:0] lat, input logic [31:0] ax, input logic sat);
    logic [31:0] el, ea;
    logic es;
    if (lat_q.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    el = lat_q.pop_front();
    ea = ax_q.pop_front();
    es = sat_q.pop_front();
    checked++;
    if (lat !== el) begin
      $error("lateral_sd expected %0d got %0d", el, lat);
      errors++;
    end
    if (ax !== ea) begin
      $error("axial_sd expected %0d got %0d", ea, ax);
      errors++;
    end
    if (sat !== es) begin
      $error("saturated expected %0d got %0d", es, sat);
      errors++;
    end
  endfunction
endclass

module depth_point_noise_sigma_tb;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic point_valid = 0;
  logic [19:0] depth_z = 0;
  logic signed [15:0] normal_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [31:0] lateral_sd;
  logic [31:0] axial_sd;
  logic saturated;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = 0;

  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;
  int sent = 0;
  int settings_used = 0;
  sigma_scoreboard board = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  depth_point_noise_sigma dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_valid(point_valid), .depth_z(depth_z), .normal_z(normal_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .lateral_sd(lateral_sd), .axial_sd(axial_sd), .saturated(saturated),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready)
      board.check_sigma(lateral_sd, axial_sd, saturated);
    if (!rst && in_valid && in_ready)
      board.note_point(point_valid, depth_z, normal_z);
    if (cycles > 400000) begin
      $display("depth_point_noise_sigma_tb: done, errors");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= (recv_idle == 0) ? 1'b1 : ($urandom_range(99) >= recv_idle);

  // valid stays high after a word is taken; the next call replaces or drops it
  task automatic send_point(input logic pv, input logic [19:0] z, input logic signed [15:0] nz);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    point_valid <= pv;
    depth_z <= z;
    normal_z <= nz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.lat_q.size() != 0) @(negedge clk);
    repeat (140) @(negedge clk);
  endtask

  task automatic set_focal(input logic [15:0] f);
    drain();
    cfg_we <= 1;
    cfg_wdata <= f;
    @(negedge clk);
    cfg_we <= 0;
    board.focal = f;
    settings_used++;
  endtask

  task automatic random_points(input int n);
    logic [19:0] z;
    logic signed [15:0] nz;
    repeat (n) begin
      case ($urandom_range(3))
        0: z = 20'($urandom);
        1: z = 20'($urandom_range(19661, 327680));
        2: z = 20'($urandom_range(1, 64));
        default: z = 20'($urandom_range(1048575 - 64, 1048575));
      endcase
      nz = ($urandom_range(3) == 0) ? 16'($urandom) : -16'($urandom_range(0, 32767));
      send_point($urandom_range(15) != 0, z, nz);
    end
  endtask

  initial begin
    logic [15:0] focals[5];
    focals = '{16'd525, 16'd1, 16'd65535, 16'd0, 16'd300};
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: field extremes, invalid point, zero depth, facing and grazing normals
    send_point(0, 20'd65536, 16'sh8000);
    send_point(1, 20'd0, 16'sh8000);
    send_point(1, 20'd1, 16'sh8000);
    send_point(1, 20'd1048575, 16'sh8000);
    send_point(1, 20'd1048575, 16'sd32767);
    send_point(1, 20'd26214, 16'sh8000);
    send_point(1, 20'd65536, 16'sd0);
    send_point(1, 20'd65536, -16'sd1);
    send_point(1, 20'd65536, -16'sd2857);
    send_point(1, 20'd65536, -16'sd23170);
    send_point(1, 20'd65536, 16'sd100);
    send_point(1, 20'd131072, -16'sd16384);
    send_point(0, 20'd0, 16'sd0);
    send_point(1, 20'h55555, 16'sh5555);
    send_point(1, 20'hAAAAA, 16'shAAAA);
    foreach (focals[i]) begin
      set_focal(focals[i]);
      send_point(1, 20'd1048575, -16'sd1);
      send_point(1, 20'd1, 16'sh8000);
      send_idle = 17; recv_idle = 70;
      random_points(80);
      send_idle = 70; recv_idle = 17;
      random_points(80);
      // hold off until every word is back
      in_valid <= 0;
      while (board.lat_q.size() != 0) @(negedge clk);
      send_idle = 0; recv_idle = 0;
      random_points(80);
    end
    drain();
    $display("covered %0d points over %0d focal settings (1, 65535, 0 among them)",
             sent, settings_used);
    $display("checked %0d result words", board.checked);
    if (board.errors == 0)
      $display("depth_point_noise_sigma_tb: done, clean");
    else
      $display("depth_point_noise_sigma_tb: done, errors");
    $finish;
  end
endmodule
